### src/sha_pkg.sv
// shared types, constants and round functions of the stream hasher
`default_nettype none
package sha_pkg;

    typedef enum logic [1:0] {
        OP_ABSORB  = 2'd0,
        OP_DIGEST  = 2'd1,
        OP_RESTART = 2'd2
    } op_t;

    typedef logic [7:0][31:0] hash_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] data;
    } item_t;

    typedef struct packed {
        logic        start;
        hash_t       chain;
        logic [31:0] word;
    } cp_ctl_t;

    typedef struct packed {
        logic       done;
        logic [3:0] round;
        hash_t      result;
    } cp_stat_t;

    typedef enum logic [1:0] {
        CP_IDLE,
        CP_ROUND,
        CP_FINISH
    } cp_state_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_RUN,
        BK_OUT
    } bk_state_t;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

    localparam logic [6:0] BLOCK_BYTES = 7'd64;
    localparam logic [6:0] LENGTH_POS  = 7'd56;
    localparam logic [7:0] PAD_BYTE    = 8'h80;
    localparam logic [5:0] LAST_BYTE   = 6'd63;
    localparam logic [5:0] LAST_ROUND  = 6'd63;
    localparam logic [3:0] LEN_HI_WORD = 4'd14;
    localparam logic [3:0] LEN_LO_WORD = 4'd15;
    localparam logic [2:0] LAST_WORD   = 3'd7;

    localparam hash_t INIT_HASH = {
        32'h5BE0CD19, 32'h1F83D9AB, 32'h9B05688C, 32'h510E527F,
        32'hA54FF53A, 32'h3C6EF372, 32'hBB67AE85, 32'h6A09E667};

    localparam logic [31:0] K_ROUND [64] = '{
        32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
        32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
        32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
        32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
        32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
        32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
        32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
        32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
        32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
        32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
        32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
        32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
        32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
        32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
        32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
        32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2};

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
    endfunction

endpackage
`default_nettype wire

### src/sha_ifs.sv
// valid/ready channel interfaces for message beats and digest beats
`default_nettype none
interface sha_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic [7:0] data_byte;

    modport source (output valid, op, data_byte, input ready);
    modport sink (input valid, op, data_byte, output ready);
endinterface

interface sha_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last;

    modport source (output valid, digest_word, word_index, last, input ready);
    modport sink (input valid, digest_word, word_index, last, output ready);
endinterface
`default_nettype wire

### src/sha256_stream_hasher.sv
// top level of the streaming sha-256 hasher
//
//  channel  dir  payload                          beat
//  msg      in   op, data_byte                    one op per beat
//  digest   out  digest_word, word_index, last    one hash word per beat
//
// the back end takes an absorb beat whenever it is idle; every 64th byte starts
// the 64 rounds of the single round-per-cycle compression unit.
// a digest compresses one block, or two when the length needs an extra block,
// then eight output beats. a four-entry queue lets msg keep taking beats
// while the back end works. reset loads the initial hash words at once; no
// clearing pass. digest stalls hold the output register and the back end.
`default_nettype none
module sha256_stream_hasher import sha_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    sha_in_if.sink    msg,
    sha_out_if.source digest
);

    item_t item;
    logic  item_valid;
    logic  item_pop;

    sha_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .msg       (msg),
        .item      (item),
        .item_valid(item_valid),
        .item_pop  (item_pop)
    );

    sha_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .item_valid(item_valid),
        .item_pop  (item_pop),
        .digest    (digest)
    );

endmodule
`default_nettype wire

### src/sha_front.sv
// front end: accepts message beats, drops unused op codes, queues the rest
`default_nettype none
module sha_front import sha_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    sha_in_if.sink    msg,
    output item_t     item,
    output logic      item_valid,
    input  wire logic item_pop
);

    item_t                q_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [QFILL_W-1:0]   fill_reg, fill_next;
    logic                 keep;
    logic                 push;

    always_comb
    begin
        unique case (msg.op) inside
            OP_ABSORB, OP_DIGEST, OP_RESTART: keep = 1'b1;
            default:                          keep = 1'b0;
        endcase
    end

    assign msg.ready  = (fill_reg != QFILL_W'(QUEUE_DEPTH));
    assign push       = msg.valid && msg.ready && keep;
    assign item       = q_mem[rd_ptr_reg];
    assign item_valid = (fill_reg != '0);

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = item_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg + QFILL_W'(push) - QFILL_W'(item_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= '{op: op_t'(msg.op), data: msg.data_byte};
        end
    end

endmodule
`default_nettype wire

### src/sha_compress.sv
// compression unit: one round per cycle with a rolling 16-word schedule window
`default_nettype none
module sha_compress import sha_pkg::*; (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire cp_ctl_t ctl,
    output cp_stat_t     stat
);

    cp_state_t          state_reg, state_next;
    logic [5:0]         cnt_reg, cnt_next;
    logic               done_reg, done_next;
    hash_t              v_reg, v_next;
    hash_t              chain_reg, chain_next;
    hash_t              result_reg, result_next;
    logic [15:0][31:0]  win_reg, win_next;
    logic [31:0]        w_cur;
    logic [31:0]        t1;
    logic [31:0]        t2;

    // first 16 rounds take block words from the buffer side
    assign w_cur = (cnt_reg < 6'd16) ? ctl.word
                 : win_reg[0] + small_sigma0(win_reg[1]) + win_reg[9]
                   + small_sigma1(win_reg[14]);

    assign t1 = v_reg[7] + big_sigma1(v_reg[4])
              + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
              + K_ROUND[cnt_reg] + w_cur;
    assign t2 = big_sigma0(v_reg[0])
              + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        done_next   = 1'b0;
        v_next      = v_reg;
        chain_next  = chain_reg;
        result_next = result_reg;
        win_next    = win_reg;
        unique case (state_reg)
            CP_IDLE:
            begin
                if (ctl.start)
                begin
                    chain_next = ctl.chain;
                    v_next     = ctl.chain;
                    cnt_next   = '0;
                    state_next = CP_ROUND;
                end
            end
            CP_ROUND:
            begin
                v_next[0] = t1 + t2;
                v_next[1] = v_reg[0];
                v_next[2] = v_reg[1];
                v_next[3] = v_reg[2];
                v_next[4] = v_reg[3] + t1;
                v_next[5] = v_reg[4];
                v_next[6] = v_reg[5];
                v_next[7] = v_reg[6];
                win_next  = {w_cur, win_reg[15:1]};
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == LAST_ROUND)
                begin
                    state_next = CP_FINISH;
                end
            end
            CP_FINISH:
            begin
                for (int i = 0; i < 8; i++)
                begin
                    result_next[i] = chain_reg[i] + v_reg[i];
                end
                done_next  = 1'b1;
                state_next = CP_IDLE;
            end
            default: state_next = CP_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CP_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg      <= v_next;
        chain_reg  <= chain_next;
        result_reg <= result_next;
        win_reg    <= win_next;
    end

    assign stat.done   = done_reg;
    assign stat.round  = cnt_reg[3:0];
    assign stat.result = result_reg;

endmodule
`default_nettype wire

### src/sha_back.sv
// back end: block buffer, padding, hash state, sequencing and digest output
`default_nettype none
module sha_back import sha_pkg::*; (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire item_t item,
    input  wire logic  item_valid,
    output logic       item_pop,
    sha_out_if.source  digest
);

    bk_state_t   state_reg, state_next;
    hash_t       hash_reg, hash_next;
    logic [5:0]  count_reg, count_next;
    logic [63:0] total_reg, total_next;
    logic [63:0] bits_reg, bits_next;
    logic [6:0]  lim_reg, lim_next;
    logic        zero_reg, zero_next;
    logic        final_reg, final_next;
    logic        job_dig_reg, job_dig_next;
    hash_t       dig_reg, dig_next;
    logic [2:0]  idx_reg, idx_next;
    logic        ov_reg, ov_next;
    logic [31:0] oword_reg, oword_next;
    logic [2:0]  oidx_reg, oidx_next;
    logic        olast_reg, olast_next;

    logic [31:0] buf_mem [16];
    logic [31:0] rd_data_reg;
    logic [3:0]  rd_addr;
    logic        wr_en;
    logic [4:0]  wr_sh;
    logic [31:0] pad_word;
    logic        out_load;

    cp_ctl_t     cp_ctl;
    cp_stat_t    cp_stat;

    sha_compress u_compress (
        .clk  (clk),
        .rst_n(rst_n),
        .ctl  (cp_ctl),
        .stat (cp_stat)
    );

    // byte lane within a word, most significant byte first
    assign wr_sh = {~count_reg[1:0], 3'b000};

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            buf_mem[count_reg[5:2]][wr_sh +: 8] <= item.data;
        end
        rd_data_reg <= buf_mem[rd_addr];
    end

    // padded block word for the round that is running now
    always_comb
    begin
        logic [6:0] b;
        pad_word = '0;
        for (int k = 0; k < 4; k++)
        begin
            b = {1'b0, cp_stat.round, 2'(k)};
            if (zero_reg)
            begin
                pad_word[31 - 8*k -: 8] = '0;
            end
            else if (b < lim_reg)
            begin
                pad_word[31 - 8*k -: 8] = rd_data_reg[31 - 8*k -: 8];
            end
            else if (b == lim_reg)
            begin
                pad_word[31 - 8*k -: 8] = PAD_BYTE;
            end
            else
            begin
                pad_word[31 - 8*k -: 8] = '0;
            end
        end
        if (final_reg && cp_stat.round == LEN_HI_WORD)
        begin
            pad_word = bits_reg[63:32];
        end
        else if (final_reg && cp_stat.round == LEN_LO_WORD)
        begin
            pad_word = bits_reg[31:0];
        end
    end

    assign out_load = !ov_reg || digest.ready;

    always_comb
    begin
        state_next   = state_reg;
        hash_next    = hash_reg;
        count_next   = count_reg;
        total_next   = total_reg;
        bits_next    = bits_reg;
        lim_next     = lim_reg;
        zero_next    = zero_reg;
        final_next   = final_reg;
        job_dig_next = job_dig_reg;
        dig_next     = dig_reg;
        idx_next     = idx_reg;
        ov_next      = ov_reg && !digest.ready;
        oword_next   = oword_reg;
        oidx_next    = oidx_reg;
        olast_next   = olast_reg;
        item_pop     = 1'b0;
        wr_en        = 1'b0;
        cp_ctl.start = 1'b0;
        cp_ctl.chain = hash_reg;
        cp_ctl.word  = pad_word;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (item_valid)
                begin
                    item_pop = 1'b1;
                    unique case (item.op)
                        OP_ABSORB:
                        begin
                            wr_en      = 1'b1;
                            total_next = total_reg + 64'd1;
                            count_next = count_reg + 1'b1;
                            if (count_reg == LAST_BYTE)
                            begin
                                cp_ctl.start = 1'b1;
                                lim_next     = BLOCK_BYTES;
                                zero_next    = 1'b0;
                                final_next   = 1'b0;
                                job_dig_next = 1'b0;
                                state_next   = BK_RUN;
                            end
                        end
                        OP_DIGEST:
                        begin
                            bits_next    = {total_reg[60:0], 3'b000};
                            lim_next     = {1'b0, count_reg};
                            zero_next    = 1'b0;
                            final_next   = ({1'b0, count_reg} < LENGTH_POS);
                            job_dig_next = 1'b1;
                            cp_ctl.start = 1'b1;
                            state_next   = BK_RUN;
                        end
                        OP_RESTART:
                        begin
                            hash_next  = INIT_HASH;
                            count_next = '0;
                            total_next = '0;
                        end
                        default: ;
                    endcase
                end
            end
            BK_RUN:
            begin
                if (cp_stat.done)
                begin
                    if (!job_dig_reg)
                    begin
                        hash_next  = cp_stat.result;
                        state_next = BK_IDLE;
                    end
                    else if (!final_reg)
                    begin
                        // length spills into a block of its own
                        cp_ctl.start = 1'b1;
                        cp_ctl.chain = cp_stat.result;
                        zero_next    = 1'b1;
                        final_next   = 1'b1;
                    end
                    else
                    begin
                        dig_next   = cp_stat.result;
                        idx_next   = '0;
                        state_next = BK_OUT;
                    end
                end
            end
            BK_OUT:
            begin
                if (out_load)
                begin
                    ov_next    = 1'b1;
                    oword_next = dig_reg[idx_reg];
                    oidx_next  = idx_reg;
                    olast_next = (idx_reg == LAST_WORD);
                    idx_next   = idx_reg + 1'b1;
                    if (idx_reg == LAST_WORD)
                    begin
                        state_next = BK_IDLE;
                    end
                end
            end
            default: state_next = BK_IDLE;
        endcase
        rd_addr = cp_ctl.start ? 4'd0 : cp_stat.round + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= BK_IDLE;
            hash_reg    <= INIT_HASH;
            count_reg   <= '0;
            total_reg   <= '0;
            zero_reg    <= 1'b0;
            final_reg   <= 1'b0;
            job_dig_reg <= 1'b0;
            idx_reg     <= '0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            hash_reg    <= hash_next;
            count_reg   <= count_next;
            total_reg   <= total_next;
            zero_reg    <= zero_next;
            final_reg   <= final_next;
            job_dig_reg <= job_dig_next;
            idx_reg     <= idx_next;
            ov_reg      <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bits_reg  <= bits_next;
        lim_reg   <= lim_next;
        dig_reg   <= dig_next;
        oword_reg <= oword_next;
        oidx_reg  <= oidx_next;
        olast_reg <= olast_next;
    end

    assign digest.valid       = ov_reg;
    assign digest.digest_word = oword_reg;
    assign digest.word_index  = oidx_reg;
    assign digest.last        = olast_reg;

endmodule
`default_nettype wire

### sim/sha256_stream_hasher_checker.sv
// checker for the stream hasher: watches both channels, predicts digests and compares them
`default_nettype none
module sha256_stream_hasher_checker import sha_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    sha_in_if         msg,
    sha_out_if        digest,
    output int        fail_count
);

    typedef struct {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } digest_beat_t;

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
        32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
        32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
        32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
        32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
        32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
        32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
        32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
        32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
        32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
        32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
        32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
        32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
        32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
        32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
        32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2};

    localparam logic [31:0] START_HASH [8] = '{
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19};

    logic [31:0]  chain [8];
    logic [7:0]   block [64];
    logic [5:0]   fill;
    logic [63:0]  msg_bytes;
    digest_beat_t pending_words [$];

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic compress_block(inout logic [31:0] h [8], input logic [7:0] b [64]);
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1, t2, s0, s1;
        for (int i = 0; i < 16; i++)
            w[i] = {b[4*i], b[4*i+1], b[4*i+2], b[4*i+3]};
        for (int i = 16; i < 64; i++)
        begin
            s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = w[i-16] + s0 + w[i-7] + s1;
        end
        v = h;
        for (int i = 0; i < 64; i++)
        begin
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[i] + w[i];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            h[i] = h[i] + v[i];
    endtask

    task automatic start_message();
        chain = START_HASH;
        foreach (block[i]) block[i] = 8'h00;
        fill = '0;
        msg_bytes = '0;
    endtask

    task automatic predict_digest();
        logic [31:0] h [8];
        logic [7:0]  b [64];
        logic [63:0] bits;
        int          n;
        h = chain;
        b = block;
        bits = msg_bytes << 3;
        n = fill;
        b[n] = 8'h80;
        n++;
        if (n > 56)
        begin
            for (int i = n; i < 64; i++) b[i] = 8'h00;
            compress_block(h, b);
            n = 0;
        end
        for (int i = n; i < 56; i++) b[i] = 8'h00;
        for (int i = 0; i < 8; i++) b[63-i] = bits[8*i +: 8];
        compress_block(h, b);
        for (int i = 0; i < 8; i++)
            pending_words.push_back('{h[i], 3'(i), i == 7});
    endtask

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("digest mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
        fail_count++;
    endtask

    initial
    begin
        fail_count = 0;
        start_message();
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (msg.valid && msg.ready)
            begin
                case (op_t'(msg.op))
                    OP_ABSORB:
                    begin
                        block[fill] = msg.data_byte;
                        msg_bytes++;
                        if (fill == 6'd63)
                            compress_block(chain, block);
                        fill++;
                    end
                    OP_DIGEST:  predict_digest();
                    OP_RESTART: start_message();
                    default:    ;
                endcase
            end
            if (digest.valid && digest.ready)
            begin
                if (pending_words.size() == 0)
                    report("unexpected beat", digest.digest_word, 32'h0);
                else
                begin
                    digest_beat_t e;
                    e = pending_words.pop_front();
                    if (digest.digest_word !== e.word)
                        report("digest_word", digest.digest_word, e.word);
                    if (digest.word_index !== e.index)
                        report("word_index", 32'(digest.word_index), 32'(e.index));
                    if (digest.last !== e.last)
                        report("last", 32'(digest.last), 32'(e.last));
                end
            end
        end
    end

    function automatic int words_pending();
        return pending_words.size();
    endfunction

endmodule
`default_nettype wire

### sim/sha256_stream_hasher_tb.sv
// testbench top: drives message beats with gaps, stalls the digest side, gives the verdict
`default_nettype none
module sha256_stream_hasher_tb import sha_pkg::*;;

    localparam int IDLE_LIMIT = 20000;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   idle_cycles;
    bit   long_hold;
    bit   stim_done;

    sha_in_if  msg ();
    sha_out_if digest ();

    sha256_stream_hasher dut (.clk(clk), .rst_n(rst_n), .msg(msg), .digest(digest));

    sha256_stream_hasher_checker checker_i (
        .clk(clk), .rst_n(rst_n), .msg(msg), .digest(digest), .fail_count(fail_count));

    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
    end

    // digest receiver: random stall pattern, quiet stretches, and one long hold-off
    initial
    begin
        int mode;
        digest.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            mode = $urandom_range(0, 3);
            if (long_hold)
            begin
                digest.ready <= 1'b0;
                repeat (400) @(posedge clk);
                long_hold = 1'b0;
            end
            repeat ($urandom_range(5, 40))
            begin
                case (mode)
                    0:       digest.ready <= 1'b1;
                    1:       digest.ready <= ($urandom_range(0, 3) != 0);
                    2:       digest.ready <= $urandom_range(0, 1);
                    default: digest.ready <= ($urandom_range(0, 4) == 0);
                endcase
                @(posedge clk);
            end
        end
    end

    // one beat, holding valid until it is taken; gap decided by the caller
    task automatic send_beat(input op_t o, input logic [7:0] b);
        msg.valid     <= 1'b1;
        msg.op        <= o;
        msg.data_byte <= b;
        do @(posedge clk); while (!msg.ready);
    endtask

    task automatic send_gap();
        msg.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
    endtask

    // burst/gap pacing around every beat
    int burst_left;
    task automatic paced_beat(input op_t o, input logic [7:0] b);
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 2) != 0) send_gap();
            burst_left = $urandom_range(1, 30);
        end
        send_beat(o, b);
        burst_left--;
    endtask

    task automatic absorb_run(input int n, input bit ones);
        for (int i = 0; i < n; i++)
            paced_beat(OP_ABSORB, ones ? 8'hFF : 8'($urandom_range(0, 255)));
    endtask

    initial
    begin
        int len;
        int sent;
        msg.valid     = 1'b0;
        msg.op        = OP_ABSORB;
        msg.data_byte = 8'h00;
        burst_left    = 0;
        long_hold     = 1'b0;
        stim_done     = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        // directed: empty message, extremes of the byte, unused op, reset of state
        paced_beat(OP_DIGEST, 8'h00);
        paced_beat(OP_ABSORB, 8'h00);
        paced_beat(OP_ABSORB, 8'hFF);
        paced_beat(OP_ABSORB, 8'hAA);
        paced_beat(OP_ABSORB, 8'h55);
        paced_beat(OP_DIGEST, 8'hFF);
        paced_beat(op_t'(2'd3), 8'h12);
        paced_beat(OP_DIGEST, 8'h00);
        paced_beat(OP_RESTART, 8'hFF);
        paced_beat(OP_DIGEST, 8'h00);
        paced_beat(OP_DIGEST, 8'h00);
        paced_beat(OP_RESTART, 8'h00);
        // lengths 55, 56, 64 exercise the single-block, extra-block and full-block cases
        absorb_run(55, 1'b1);
        paced_beat(OP_DIGEST, 8'h00);
        absorb_run(1, 1'b0);
        paced_beat(OP_DIGEST, 8'h00);
        absorb_run(8, 1'b0);
        paced_beat(OP_DIGEST, 8'h00);
        paced_beat(OP_RESTART, 8'h00);
        // long hold on the digest side while beats keep coming
        long_hold = 1'b1;
        for (int i = 0; i < 6; i++)
            paced_beat(OP_DIGEST, 8'h00);
        absorb_run(20, 1'b0);
        // random messages, mostly short, with digests, restarts and noise
        sent = 0;
        while (sent < 360)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5:
                begin
                    len = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 130)
                                                      : $urandom_range(0, 12);
                    absorb_run(len, 1'b0);
                    sent += len;
                end
                6, 7:
                begin
                    paced_beat(OP_DIGEST, 8'($urandom_range(0, 255)));
                    sent++;
                end
                8:
                begin
                    paced_beat(OP_RESTART, 8'($urandom_range(0, 255)));
                    sent++;
                end
                default:
                begin
                    paced_beat(op_t'(2'd3), 8'($urandom_range(0, 255)));
                    sent++;
                end
            endcase
        end
        paced_beat(OP_DIGEST, 8'h00);
        msg.valid <= 1'b0;
        stim_done = 1'b1;
    end

    // verdict and watchdog
    initial
    begin
        idle_cycles = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if ((msg.valid && msg.ready) || (digest.valid && digest.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
            if (stim_done && checker_i.words_pending() == 0)
            begin
                repeat (300) @(posedge clk);
                if (fail_count == 0 && checker_i.words_pending() == 0)
                    $display("*** PASSED ***");
                else
                    $display("*** FAILED ***");
                $finish;
            end
        end
    end

endmodule
`default_nettype wire

### files.f
src/sha_pkg.sv
src/sha_ifs.sv
src/sha_front.sv
src/sha_compress.sv
src/sha_back.sv
src/sha256_stream_hasher.sv
sim/sha256_stream_hasher_checker.sv
sim/sha256_stream_hasher_tb.sv
